// File: design/bdlp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdlp_pkg: shared definitions for the pushbutton qualifier
// Mode codes, register indexes, reset values and the configuration and
// result structures used by the qualifier modules.
// ----------------------------------------------------------------------------
package bdlp_pkg;

    localparam int CountWidthDefault = 8;

    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 8;

    // Press mode codes.
    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_NORMAL = 2'd1;
    localparam logic [1:0] MODE_ACCEL  = 2'd2;
    localparam logic [1:0] MODE_ALT    = 2'd3;

    // Configuration register indexes.
    localparam logic [CfgIndexWidth-1:0] REG_PRESS_MODE    = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_DEBOUNCE      = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_RELEASE_CHECK = 3'd2;
    localparam logic [CfgIndexWidth-1:0] REG_LONG_PRESS    = 3'd3;
    localparam logic [CfgIndexWidth-1:0] REG_REPEAT        = 3'd4;

    // Register values after reset.
    localparam logic [7:0] DEBOUNCE_RESET      = 8'd2;
    localparam logic [7:0] RELEASE_CHECK_RESET = 8'd2;
    localparam logic [7:0] LONG_PRESS_RESET    = 8'd50;
    localparam logic [7:0] REPEAT_RESET        = 8'd25;

    typedef struct packed {
        logic [1:0] press_mode;
        logic [7:0] debounce_ticks;
        logic [7:0] release_check_ticks;
        logic [7:0] long_press_checks;
        logic [7:0] repeat_ticks;
    } cfg_t;

    typedef struct packed {
        logic fire_normal;
        logic fire_alt;
        logic busy;
    } result_t;

endpackage
`default_nettype wire

// File: design/button_debounce_long_press_repeat.sv
`default_nettype none
// ----------------------------------------------------------------------------
// button_debounce_long_press_repeat: pushbutton qualifier with long press
// and auto-repeat
// One sampled button level per beat in, one result beat out per input beat.
// ----------------------------------------------------------------------------
// Each input beat is one timer tick carrying the sampled level of a single
// pushbutton, and each one produces exactly one result beat holding the
// normal pulse, the alternate pulse and a busy flag. The block sustains one
// beat per clock cycle while the output is not stalled: a beat lands in an
// input register, passes through one step of the qualifier state machine,
// and its result lands in a result register, which offers it. The
// single-step update of the phase and the two countdown counters between
// those registers sets that rate. Input is taken while a finished result
// waits, as long as the input register can move on or is empty.
// Configuration writes take effect at once and should be made only while no
// beat is in flight.
// ----------------------------------------------------------------------------
module button_debounce_long_press_repeat
    import bdlp_pkg::*;
#(
    parameter int COUNT_WIDTH = CountWidthDefault
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    // Configuration write port.
    input  wire logic                     cfg_write,
    input  wire logic [CfgIndexWidth-1:0] cfg_index,
    input  wire logic [CfgDataWidth-1:0]  cfg_data,

    // Input channel.
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic                     button_pressed,

    // Result channel.
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic                          fire_normal,
    output logic                          fire_alt,
    output logic                          busy_res
);

    cfg_t    cfg;
    result_t step_result;

    logic stage_valid_reg;
    logic button_reg;
    logic out_valid_reg;
    logic fire_normal_reg;
    logic fire_alt_reg;
    logic busy_reg;
    logic out_free;
    logic advance;
    logic in_take;

    bdlp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The state machine steps exactly when a beat moves from the input
    // register into the result register, which keeps the state in beat order.
    bdlp_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .pressed (button_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = stage_valid_reg && out_free;
    assign in_stall = stage_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                stage_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            button_reg <= button_pressed;
        end
        if (advance)
        begin
            fire_normal_reg <= step_result.fire_normal;
            fire_alt_reg    <= step_result.fire_alt;
            busy_reg        <= step_result.busy;
        end
    end

    assign out_valid   = out_valid_reg;
    assign fire_normal = fire_normal_reg;
    assign fire_alt    = fire_alt_reg;
    assign busy_res    = busy_reg;

endmodule
`default_nettype wire

// File: design/bdlp_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdlp_cfg: configuration register file
// Holds the five qualifier settings and decodes plain register writes.
// ----------------------------------------------------------------------------
module bdlp_cfg
    import bdlp_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_write,
    input  wire logic [CfgIndexWidth-1:0] cfg_index,
    input  wire logic [CfgDataWidth-1:0]  cfg_data,
    output cfg_t                          cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.press_mode          <= MODE_NORMAL;
            cfg_reg.debounce_ticks      <= DEBOUNCE_RESET;
            cfg_reg.release_check_ticks <= RELEASE_CHECK_RESET;
            cfg_reg.long_press_checks   <= LONG_PRESS_RESET;
            cfg_reg.repeat_ticks        <= REPEAT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PRESS_MODE:    cfg_reg.press_mode          <= cfg_data[1:0];
                REG_DEBOUNCE:      cfg_reg.debounce_ticks      <= cfg_data;
                REG_RELEASE_CHECK: cfg_reg.release_check_ticks <= cfg_data;
                REG_LONG_PRESS:    cfg_reg.long_press_checks   <= cfg_data;
                REG_REPEAT:        cfg_reg.repeat_ticks        <= cfg_data;
                default:           ; // Writes beyond the register list are dropped.
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// File: design/bdlp_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdlp_core: press qualifier state machine
// Holds phase and the two countdown counters and computes the per-tick
// update and its pulses from one sampled button level.
// ----------------------------------------------------------------------------
module bdlp_core
    import bdlp_pkg::*;
#(
    parameter int COUNT_WIDTH = CountWidthDefault
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic step,
    input  wire logic pressed,
    input  wire cfg_t cfg,
    output result_t   result
);

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_DEBOUNCE  = 3'd1;
    localparam logic [2:0] PH_CONFIRMED = 3'd2;
    localparam logic [2:0] PH_EXTENDED  = 3'd3;
    localparam logic [2:0] PH_REPEAT    = 3'd4;

    localparam logic [COUNT_WIDTH-1:0] CountOne  = COUNT_WIDTH'(1);
    localparam logic [COUNT_WIDTH-1:0] CountZero = '0;

    logic [2:0]             phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] tick_reg, tick_next;
    logic [COUNT_WIDTH-1:0] hold_reg, hold_next;
    logic [COUNT_WIDTH-1:0] tick_dec, hold_dec;
    logic [COUNT_WIDTH-1:0] load_debounce, load_release, load_long, load_repeat;
    logic                   on;
    logic                   fire_normal, fire_alt;

    // Settings are taken modulo the counter width.
    assign load_debounce = COUNT_WIDTH'(cfg.debounce_ticks);
    assign load_release  = COUNT_WIDTH'(cfg.release_check_ticks);
    assign load_long     = COUNT_WIDTH'(cfg.long_press_checks);
    assign load_repeat   = COUNT_WIDTH'(cfg.repeat_ticks);

    assign on       = (cfg.press_mode != MODE_OFF);
    assign tick_dec = tick_reg - CountOne;
    assign hold_dec = hold_reg - CountOne;

    always_comb
    begin
        phase_next  = phase_reg;
        tick_next   = tick_reg;
        hold_next   = hold_reg;
        fire_normal = 1'b0;
        fire_alt    = 1'b0;
        unique case (phase_reg) inside
            PH_DEBOUNCE, PH_CONFIRMED, PH_EXTENDED, PH_REPEAT:
            begin
                tick_next = tick_dec;
                if (tick_dec == CountZero)
                begin
                    if (phase_reg == PH_DEBOUNCE)
                    begin
                        if (!pressed)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_CONFIRMED;
                            hold_next  = load_long;
                            tick_next  = load_release;
                        end
                    end
                    else if (phase_reg == PH_CONFIRMED)
                    begin
                        if (!pressed)
                        begin
                            fire_normal = on;
                            phase_next  = PH_IDLE;
                        end
                        else
                        begin
                            hold_next = hold_dec;
                            tick_next = load_release;
                            if (hold_dec == CountZero)
                            begin
                                if (cfg.press_mode == MODE_ACCEL)
                                begin
                                    phase_next  = PH_REPEAT;
                                    fire_normal = 1'b1;
                                    tick_next   = load_repeat;
                                end
                                else
                                begin
                                    phase_next = PH_EXTENDED;
                                end
                            end
                        end
                    end
                    else if (phase_reg == PH_EXTENDED)
                    begin
                        if (!pressed)
                        begin
                            fire_normal = (cfg.press_mode == MODE_NORMAL);
                            fire_alt    = (cfg.press_mode == MODE_ALT);
                            phase_next  = PH_IDLE;
                        end
                        else
                        begin
                            tick_next = load_release;
                        end
                    end
                    else
                    begin
                        if (!pressed)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            fire_normal = on;
                            tick_next   = load_repeat;
                        end
                    end
                end
            end
            default:
            begin
                // Idle, and the unused codes, which behave as idle.
                phase_next = PH_IDLE;
                if (pressed && on)
                begin
                    phase_next = PH_DEBOUNCE;
                    tick_next  = load_debounce;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            hold_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            hold_reg  <= hold_next;
        end
    end

    assign result.fire_normal = fire_normal;
    assign result.fire_alt    = fire_alt;
    assign result.busy        = (phase_next != PH_IDLE);

endmodule
`default_nettype wire
